[design/assert_macros.svh]
// Assertion helpers shared by the RTL. Each check is clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[design/sha256_pkg.sv]
`default_nettype none

package sha256_pkg;

  localparam int WORD_W = 32;

  // Standard initial hash values, element 0 is H0.
  localparam logic [7:0][WORD_W-1:0] SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Round constants, indexed by round number.
  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Commands from the sequencer to the message window and the round unit.
  typedef struct packed {
    logic       byte_en;    // a message or padding byte enters the window
    logic [7:0] byte_val;
    logic       word_push;  // the byte completes a 32-bit word
    logic       init_vars;  // copy the chaining words into the working variables
    logic       round_en;   // run one compression round
    logic [5:0] round;      // current round number
    logic       fold;       // add the working variables into the chaining words
    logic       restart;    // return the chaining words to the initial values
  } ctl_t;

endpackage

`default_nettype wire

[design/sha256_sched.sv]
`default_nettype none

module sha256_sched (
  input  wire                               clk,
  input  wire  sha256_pkg::ctl_t            ctl,
  output logic [sha256_pkg::WORD_W-1:0]     w_t
);
  import sha256_pkg::*;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] sig0(input logic [WORD_W-1:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] sig1(input logic [WORD_W-1:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  logic [23:0]             acc;
  logic [WORD_W-1:0]       win [16];
  logic [WORD_W-1:0]       expand;

  // Next schedule word, sixteen words ahead of the oldest word in the window.
  assign expand = sig1(win[14]) + win[9] + sig0(win[1]) + win[0];
  assign w_t    = win[0];

  // Bytes gather big-endian into words, which then shift into the window.
  always_ff @(posedge clk) begin
    if (ctl.byte_en) begin
      acc <= {acc[15:0], ctl.byte_val};
    end
    if (ctl.word_push || ctl.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= ctl.word_push ? {acc, ctl.byte_val} : expand;
    end
  end

endmodule

`default_nettype wire

[design/sha256_round.sv]
`default_nettype none

module sha256_round (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire  sha256_pkg::ctl_t                ctl,
  input  wire  [sha256_pkg::WORD_W-1:0]         w_t,
  output logic [7:0][sha256_pkg::WORD_W-1:0]    chain
);
  import sha256_pkg::*;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  logic [7:0][WORD_W-1:0] v;
  logic [WORD_W-1:0]      big0;
  logic [WORD_W-1:0]      big1;
  logic [WORD_W-1:0]      choose;
  logic [WORD_W-1:0]      major;
  logic [WORD_W-1:0]      tmp1;
  logic [WORD_W-1:0]      tmp2;

  // One compression round on the working variables a..h (v[0]..v[7]).
  always_comb begin
    big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    tmp1   = v[7] + big1 + choose + ROUND_K[ctl.round] + w_t;
    tmp2   = big0 + major;
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (ctl.init_vars) begin
      v <= chain;
    end else if (ctl.round_en) begin
      v <= {v[6], v[5], v[4], v[3] + tmp1, v[2], v[1], v[0], tmp1 + tmp2};
    end
  end

  // Chaining words.
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      chain <= SHA_IV;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + v[i];
      end
    end
  end

endmodule

`default_nettype wire

[design/sha256_stream_hasher.sv]
// SHA-256 hasher over a byte stream.
// Slave channel: each request brings one byte in s_tdata with s_tuser = 0, or a
// finish request with s_tuser = 1 (s_tdata ignored) that closes the message.
// Master channel: after a finish the eight digest words leave in order, H0 first,
// each with its index; m_tlast marks the eighth word.
// Timing: while the block buffer fills, a byte is taken every cycle. The 64th byte
// of a block starts the compression: the rounds on the one round unit, then the
// fold into the chaining words, during which s_tready is low.
// A finish inserts padding and length bytes one per cycle up to the block end, then
// compresses (twice when 56 or more bytes were buffered). The first digest word is
// valid soonest after the finish request with 55 bytes buffered and latest with 56,
// plus any wait for the receiver to take an earlier digest word.
// The digest goes through a one-word output register; a stalled receiver holds the
// word and the block waits. Once the eighth word is loaded, the state returns to the
// initial hash values and new bytes are taken while that word waits.
// Reset (rst, synchronous) clears the bit count, buffer fill and sequencer, and
// loads the initial hash values. The bit count wraps modulo 2^64.
`default_nettype none
`include "assert_macros.svh"

module sha256_stream_hasher (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire  [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_tlast    // last_word
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic       KIND_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_START   = 6'd56;
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] ROUND_LAST  = 6'd63;
  localparam logic [2:0] WORD_LAST   = 3'd7;

  logic [2:0]              state;
  logic [5:0]              fill;
  logic [54:0]             blocks;
  logic                    padding;
  logic                    final_blk;
  logic [5:0]              round;
  logic [2:0]              emit_idx;
  logic [63:0]             len_sh;
  logic [WORD_W-1:0]       out_word;
  logic [2:0]              out_index;

  logic                    s_accept;
  logic                    inject;
  logic [7:0]              inject_byte;
  logic                    load_out;
  logic                    last_load;
  logic                    last_round;
  ctl_t                    ctl;
  logic [WORD_W-1:0]       w_t;
  logic [7:0][WORD_W-1:0]  chain;

  assign s_tready   = (state == S_IDLE);
  assign s_accept   = s_tvalid && s_tready;
  assign load_out   = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign last_load  = load_out && (emit_idx == WORD_LAST);
  assign last_round = (state == S_ROUND) && (round == ROUND_LAST);
  assign m_tdata    = {5'b0, out_index, out_word};

  // Byte source for the message window: the request, padding or length.
  always_comb begin
    inject      = 1'b0;
    inject_byte = 8'h00;
    unique case (state)
      S_IDLE: begin
        inject      = s_accept;
        inject_byte = (s_tuser[0] == KIND_FINISH) ? PAD_BYTE : s_tdata;
      end
      S_PAD: begin
        inject = (fill != LEN_START);
      end
      S_LEN: begin
        inject      = 1'b1;
        inject_byte = len_sh[63:56];
      end
      default: begin
      end
    endcase
  end

  // Commands to the window and the round unit.
  always_comb begin
    ctl           = '0;
    ctl.byte_en   = inject;
    ctl.byte_val  = inject_byte;
    ctl.word_push = inject && (fill[1:0] == 2'b11);
    ctl.init_vars = inject && (fill == FILL_LAST);
    ctl.round_en  = (state == S_ROUND);
    ctl.round     = round;
    ctl.fold      = (state == S_FOLD);
    ctl.restart   = last_load;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      blocks    <= '0;
      padding   <= 1'b0;
      final_blk <= 1'b0;
      round     <= '0;
      emit_idx  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (inject) begin
        fill <= fill + 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            final_blk <= 1'b0;
            if (s_tuser[0] == KIND_FINISH) begin
              padding <= 1'b1;
              state   <= (fill == FILL_LAST) ? S_ROUND : S_PAD;
            end else if (fill == FILL_LAST) begin
              blocks <= blocks + 55'd1;
              state  <= S_ROUND;
            end
          end
        end
        S_PAD: begin
          if (fill == LEN_START) begin
            state <= S_LEN;
          end else if (fill == FILL_LAST) begin
            state <= S_ROUND;
          end
        end
        S_LEN: begin
          if (fill == FILL_LAST) begin
            final_blk <= 1'b1;
            state     <= S_ROUND;
          end
        end
        S_ROUND: begin
          round <= round + 6'd1;
          if (round == ROUND_LAST) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (final_blk) begin
            state <= S_EMIT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == WORD_LAST) begin
              state     <= S_IDLE;
              blocks    <= '0;
              padding   <= 1'b0;
              final_blk <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Output register valid.
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Length capture and output payload.
  always_ff @(posedge clk) begin
    if (s_accept && (s_tuser[0] == KIND_FINISH)) begin
      len_sh <= {blocks, fill, 3'b000};
    end else if (state == S_LEN) begin
      len_sh <= {len_sh[55:0], 8'h00};
    end
    if (load_out) begin
      out_word  <= chain[emit_idx];
      out_index <= emit_idx;
      m_tlast   <= (emit_idx == WORD_LAST);
    end
  end

  sha256_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w_t (w_t)
  );

  sha256_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .w_t   (w_t),
    .chain (chain)
  );

  `ASSERT_CLK(a_round_to_fold, last_round |=> (state == S_FOLD), "no fold after the last round")
  `ASSERT_NEVER(a_emit_fill, (state == S_EMIT) && (fill != 6'd0), "digest with bytes buffered")
  `ASSERT_NEVER(a_len_fill, (state == S_LEN) && (fill[5:3] != 3'b111), "length bytes misplaced")
  `ASSERT_CLK(a_emit_done, last_load |=> (state == S_IDLE && emit_idx == 3'd0), "bad digest end")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;
  localparam int   DIGEST_WORDS = 8;
  localparam int   TARGET_ITEMS = 430;
  localparam int   IDLE_LIMIT   = 3000;
  localparam int   DRAIN_CYCLES = 300;
  localparam int   MAX_REPORTS  = 10;

  // One request on the slave side.
  typedef struct {
    logic       kind;
    logic [7:0] data;
    bit         wait_idle;  // hold this request until all digests have come back
  } hash_req_t;

  // One digest word as it should leave the master side.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]  s_tuser = 1'b0;    // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [31:0] digest_word, [34:32] word_index, [39:35] zero
  logic        m_tlast;

  hash_req_t    pending_reqs[$];
  digest_word_t digest_expected[$];
  int           fail_count = 0;

  // Hash state kept alongside the block.
  logic [31:0] chain_state [8];
  logic [7:0]  block_buf [64];
  logic [5:0]  fill_cnt;
  logic [63:0] msg_bits;

  sha256_stream_hasher u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Return the chaining words to the standard initial values and clear the fill and bit count.
  function automatic void restart_hash();
    chain_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill_cnt = '0;
    msg_bits = '0;
  endfunction

  // Full 64-round compression of the buffered block into the chaining words.
  function automatic void compress_block();
    logic [31:0] rk [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    for (int t = 0; t < 16; t++)
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = chain_state;
    for (int t = 0; t < 64; t++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + s1 + ch + rk[t] + w[t];
      t2 = s0 + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain_state[i] = chain_state[i] + v[i];
  endfunction

  // Apply one accepted request; a finish queues the eight digest words.
  function automatic void hash_request(logic kind, logic [7:0] data);
    logic [63:0]  total;
    int           pos;
    digest_word_t dw;
    if (kind == KIND_BYTE) begin
      block_buf[fill_cnt] = data;
      fill_cnt = fill_cnt + 6'd1;
      if (fill_cnt == 6'd0) begin
        compress_block();
        msg_bits = msg_bits + 64'd512;
      end
    end else begin
      total = msg_bits + {55'd0, fill_cnt, 3'b000};
      pos = int'(fill_cnt);
      block_buf[pos] = 8'h80;
      pos++;
      // No room left for the length: close this block and start another.
      if (fill_cnt >= 6'd56) begin
        for (int i = pos; i < 64; i++)
          block_buf[i] = 8'h00;
        compress_block();
        pos = 0;
      end
      for (int i = pos; i < 56; i++)
        block_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++)
        block_buf[63-i] = total[8*i +: 8];
      compress_block();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        dw.word = chain_state[i];
        dw.index = i[2:0];
        dw.last = (i == DIGEST_WORDS - 1);
        digest_expected.push_back(dw);
      end
      restart_hash();
    end
  endfunction

  function automatic void report_error(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function automatic void add_req(logic kind, logic [7:0] data, bit wait_idle);
    hash_req_t r;
    r.kind = kind;
    r.data = data;
    r.wait_idle = wait_idle;
    pending_reqs.push_back(r);
  endfunction

  // A message of random bytes followed by its finish request.
  function automatic void add_message(int len, bit wait_idle);
    for (int i = 0; i < len; i++)
      add_req(KIND_BYTE, 8'($urandom_range(0, 255)), wait_idle && (i == 0));
    add_req(KIND_FINISH, 8'($urandom_range(0, 255)), wait_idle && (len == 0));
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : req_driver
    bit send;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        hash_request(s_tuser[0], s_tdata);
        void'(pending_reqs.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        send = 1'b0;
        if (gap_left > 0)
          gap_left--;
        else if (pending_reqs.size() > 0 &&
                 !(pending_reqs[0].wait_idle && digest_expected.size() > 0))
          send = 1'b1;
        if (send) begin
          s_tuser <= pending_reqs[0].kind;
          s_tdata <= pending_reqs[0].data;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        s_tvalid <= send;
      end
    end
  end

  // Digest monitor with a rotating stall pattern on m_tready.
  logic [15:0] stall_pat = 16'hffff;
  int          pat_age = 0;

  always @(posedge clk) begin : digest_monitor
    digest_word_t exp_w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (digest_expected.size() == 0) begin
          report_error($sformatf("unexpected digest word %h index %0d last %b",
                                 m_tdata[31:0], m_tdata[34:32], m_tlast));
        end else begin
          exp_w = digest_expected.pop_front();
          if (m_tdata[31:0] !== exp_w.word || m_tdata[34:32] !== exp_w.index ||
              m_tlast !== exp_w.last)
            report_error($sformatf("digest word exp %h/%0d/%b got %h/%0d/%b",
                                   exp_w.word, exp_w.index, exp_w.last,
                                   m_tdata[31:0], m_tdata[34:32], m_tlast));
        end
      end
      pat_age++;
      if (pat_age >= 64) begin
        pat_age = 0;
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      m_tready <= stall_pat[0];
    end
  end

  // Watchdog on cycles with no handshake on either side.
  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int boundary_lens [10] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 128};
    int first_lens [4] = '{56, 64, 63, 120};
    int len;
    bit mid_pause_done;
    restart_hash();

    // Directed: empty messages back to back, "abc", and extreme byte values.
    add_req(KIND_FINISH, 8'hff, 1'b0);
    add_req(KIND_FINISH, 8'h00, 1'b0);
    add_req(KIND_BYTE, 8'h61, 1'b0);
    add_req(KIND_BYTE, 8'h62, 1'b0);
    add_req(KIND_BYTE, 8'h63, 1'b0);
    add_req(KIND_FINISH, 8'h5a, 1'b0);
    add_req(KIND_BYTE, 8'h00, 1'b0);
    add_req(KIND_BYTE, 8'hff, 1'b0);
    add_req(KIND_BYTE, 8'h80, 1'b0);
    add_req(KIND_BYTE, 8'h7f, 1'b0);
    add_req(KIND_FINISH, 8'ha5, 1'b0);

    // Random messages: block-boundary lengths first, then a mix of short and
    // boundary lengths. Two messages wait for all digests before starting.
    foreach (first_lens[i])
      add_message(first_lens[i], i == 0);
    mid_pause_done = 1'b0;
    while (pending_reqs.size() < TARGET_ITEMS) begin
      if ($urandom_range(0, 9) < 4)
        len = boundary_lens[$urandom_range(0, 9)];
      else
        len = $urandom_range(0, 40);
      // The last message is cut short so the total stays at the target.
      if (len >= TARGET_ITEMS - pending_reqs.size())
        len = TARGET_ITEMS - pending_reqs.size() - 1;
      add_message(len, !mid_pause_done && pending_reqs.size() >= TARGET_ITEMS / 2);
      if (pending_reqs.size() >= TARGET_ITEMS / 2)
        mid_pause_done = 1'b1;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0)
      @(posedge clk);
    while (digest_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
